/* sv/ppcenc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppcenc_pkg
// Shared types, codes and field builders for the PowerPC64 encoder.
// ----------------------------------------------------------------------------
package ppcenc_pkg;

   typedef enum logic [2:0] {
      ERR_OK        = 3'd0,
      ERR_ADDRESS   = 3'd1,
      ERR_ARGUMENT  = 3'd2,
      ERR_TOO_LARGE = 3'd3,
      ERR_ALIGN     = 3'd4,
      ERR_UNKNOWN   = 3'd5
   } err_type;

   typedef enum logic [1:0] {
      EXP_ONE    = 2'd0,
      EXP_LOADIMM = 2'd1,
      EXP_PROLOG = 2'd2,
      EXP_EPILOG = 2'd3
   } exp_type;

   localparam logic [6:0] CMD_LOADIMM = 7'd6;
   localparam logic [6:0] CMD_PROLOG  = 7'd103;
   localparam logic [6:0] CMD_EPILOG  = 7'd104;
   localparam logic [6:0] CMD_LAST    = 7'd104;

   localparam int QDEPTH = 2;
   localparam int QAW    = 1;

   // classified request handed from front to back
   typedef struct packed {
      logic [31:0] word;
      err_type     err;
      exp_type     kind;
      logic [4:0]  rd;
      logic [63:0] imm;
      logic [15:0] frame;
   } job_type;

   typedef struct packed {
      logic [31:0] word;
      err_type     err;
      logic        last;
   } beat_type;

   function automatic logic [31:0] dform(input logic [5:0] op, input logic [4:0] d,
                                         input logic [4:0] a, input logic [15:0] lo);
      dform = {op, d, a, lo};
   endfunction

   function automatic logic [31:0] xform(input logic [5:0] op, input logic [4:0] d,
                                         input logic [4:0] a, input logic [4:0] b,
                                         input logic [9:0] xo);
      xform = {op, d, a, b, xo, 1'b0};
   endfunction

   function automatic logic [31:0] mdform(input logic [4:0] rs, input logic [4:0] ra,
                                          input logic [7:0] sh, input logic [7:0] mb,
                                          input logic [3:0] kind);
      mdform = {6'd30, rs, ra, sh[4:0], mb[4:0], mb[5], 3'b000, sh[5], 1'b0}
               | {28'd0, kind};
   endfunction

   function automatic logic [31:0] mform(input logic [5:0] op, input logic [4:0] rs,
                                         input logic [4:0] ra, input logic [7:0] sh,
                                         input logic [7:0] mb, input logic [7:0] me);
      mform = {op, rs, ra, sh[4:0], mb[4:0], me[4:0], 1'b0};
   endfunction

endpackage

/* sv/ppc64_instruction_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc64_instruction_encoder
// PowerPC64 assembler request encoder with APB register port.
// ----------------------------------------------------------------------------
// Path from push to first word: decode queue, then output register.
// Throughput: one word per cycle while every beat is popped; single-word requests
// at one per cycle, loadImm64/prolog/epilog expand to 5/3/4 words each.
// Reset: synchronous; queue and output empty, little_endian 1, min frame 32.
module ppc64_instruction_encoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [6:0]         req_cmd,
   input  logic [4:0]         req_reg_d,
   input  logic [4:0]         req_reg_a,
   input  logic [4:0]         req_reg_b,
   input  logic [63:0]        req_imm,
   input  logic signed [31:0] req_offset,
   input  logic [7:0]         req_shift,
   input  logic [7:0]         req_mask_begin,
   input  logic [7:0]         req_mask_end,
   input  logic               req_base_en,
   input  logic               req_index_en,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [31:0]        rsp_word_bytes,
   output logic [2:0]         rsp_error,
   output logic               rsp_last,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import ppcenc_pkg::*;

   logic        le_ff, le_in;
   logic [14:0] mf_ff, mf_in;
   job_type     fjob, qjob;
   job_type     q_ff [QDEPTH];
   logic [QAW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [QAW:0]   cnt_ff, cnt_in;
   logic        push, take, wr;
   beat_type    beat;
   logic        bvalid;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      le_in = le_ff;
      mf_in = mf_ff;
      if (wr && csr_paddr == 3'd0) le_in = csr_pwdata[0];
      if (wr && csr_paddr == 3'd4) mf_in = csr_pwdata[14:0];
      case (csr_paddr)
         3'd0:    csr_prdata = {31'd0, le_ff};
         3'd4:    csr_prdata = {17'd0, mf_ff};
         default: csr_prdata = '0;
      endcase
   end

   ppcenc_front u_front (
      .cmd(req_cmd), .reg_d(req_reg_d), .reg_a(req_reg_a), .reg_b(req_reg_b),
      .imm(req_imm), .offset(req_offset), .shift(req_shift),
      .mask_begin(req_mask_begin), .mask_end(req_mask_end),
      .base_en(req_base_en), .index_en(req_index_en),
      .min_frame(mf_ff), .job(fjob)
   );

   assign req_full = (cnt_ff == QDEPTH[QAW:0]);
   assign push = req_push && !req_full;
   assign qjob = q_ff[rp_ff];

   always_comb begin
      wp_in = push ? wp_ff + 1'b1 : wp_ff;
      rp_in = take ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         le_ff  <= 1'b1;
         mf_ff  <= 15'd32;
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         le_ff  <= le_in;
         mf_ff  <= mf_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wp_ff] <= fjob;
   end

   ppcenc_back u_back (
      .clock(clock), .reset(reset), .job(qjob), .job_valid(cnt_ff != '0),
      .job_take(take), .little_endian(le_ff), .beat(beat), .beat_valid(bvalid),
      .beat_take(rsp_pop)
   );

   assign rsp_empty = !bvalid;
   assign rsp_word_bytes = beat.word;
   assign rsp_error = beat.err;
   assign rsp_last = beat.last;

endmodule

/* sv/ppcenc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppcenc_front
// Decodes one request into a base word or an expansion job, with checks.
// ----------------------------------------------------------------------------
module ppcenc_front (
   input  logic [6:0]                 cmd,
   input  logic [4:0]                 reg_d,
   input  logic [4:0]                 reg_a,
   input  logic [4:0]                 reg_b,
   input  logic [63:0]                imm,
   input  logic signed [31:0]         offset,
   input  logic [7:0]                 shift,
   input  logic [7:0]                 mask_begin,
   input  logic [7:0]                 mask_end,
   input  logic                       base_en,
   input  logic                       index_en,
   input  logic [14:0]                min_frame,
   output ppcenc_pkg::job_type        job
);
   import ppcenc_pkg::*;

   logic [4:0]  d, a, b;
   logic [15:0] i16, u16;
   logic [7:0]  sh, mb, me;
   logic        off16, dok, dok4, xok;
   logic [31:0] w;
   err_type     e;

   always_comb begin
      d = reg_d; a = reg_a; b = reg_b;
      i16 = imm[15:0]; u16 = offset[15:0];
      sh = shift; mb = mask_begin; me = mask_end;
      off16 = (offset >= -32'sd32768) && (offset <= 32'sd32767);
      dok  = base_en && !index_en && off16;
      dok4 = dok && (offset[1:0] == 2'b00);
      xok  = base_en && index_en;
      w = '0; e = ERR_OK;
      job.kind = EXP_ONE;
      case (cmd)
         7'd0: w = dform(6'd14, d, 5'd0, i16);
         7'd1: w = dform(6'd14, d, a, i16);
         7'd2: w = dform(6'd15, d, a, i16);
         7'd3: w = dform(6'd24, d, a, i16);
         7'd4: w = dform(6'd25, d, a, i16);
         7'd5: w = (sh == 8'd0) ? xform(6'd31, d, a, d, 10'd444)
                                : mdform(d, a, sh, 8'd63 - sh, 4'd4);
         7'd6: job.kind = EXP_LOADIMM;
         7'd7:  w = xform(6'd31, d, a, b, 10'd266);
         7'd8:  w = xform(6'd31, d, a, b, 10'd10);
         7'd9:  w = xform(6'd31, d, a, 5'd0, 10'd202);
         7'd10: w = xform(6'd31, d, a, 5'd0, 10'd234);
         7'd11: w = xform(6'd31, d, a, b, 10'd40);
         7'd12: w = xform(6'd31, d, a, b, 10'd8);
         7'd13: w = xform(6'd31, d, a, 5'd0, 10'd200);
         7'd14: w = xform(6'd31, d, a, 5'd0, 10'd232);
         7'd15: w = xform(6'd31, d, a, 5'd0, 10'd104);
         7'd16: w = xform(6'd31, d, a, b, 10'd28);
         7'd17: w = xform(6'd31, d, a, b, 10'd444);
         7'd18: w = xform(6'd31, d, a, b, 10'd316);
         7'd19: w = xform(6'd31, d, a, b, 10'd27);
         7'd20: w = xform(6'd31, d, a, b, 10'd539);
         7'd21: w = xform(6'd31, d, a, b, 10'd794);
         7'd22: w = xform(6'd31, d, a, 5'd0, 10'd986);
         7'd23: w = xform(6'd31, d, a, 5'd0, 10'd954);
         7'd24: w = xform(6'd31, d, a, 5'd0, 10'd922);
         7'd25: w = xform(6'd31, d, a, b, 10'd233);
         7'd26: w = xform(6'd31, d, a, b, 10'd235);
         7'd27: w = xform(6'd31, d, a, b, 10'd9);
         7'd28: w = xform(6'd31, d, a, b, 10'd73);
         7'd29: w = xform(6'd31, d, a, b, 10'd75);
         7'd30: w = xform(6'd31, d, a, b, 10'd11);
         7'd31: w = dform(6'd7, d, a, i16);
         7'd32: w = xform(6'd31, d, a, b, 10'd489);
         7'd33: w = xform(6'd31, d, a, b, 10'd491);
         7'd34: w = xform(6'd31, d, a, b, 10'd457);
         7'd35: w = xform(6'd31, d, a, b, 10'd459);
         7'd36: w = xform(6'd31, d, a, sh[4:0], 10'd824);
         7'd37: w = mdform(d, a, 8'd64 - sh, sh, 4'd0);
         7'd38: w = dform(6'd28, d, a, i16);
         7'd39: w = dform(6'd29, d, a, i16);
         7'd40: w = dform(6'd26, d, a, i16);
         7'd41: w = dform(6'd27, d, a, i16);
         7'd42: w = xform(6'd31, 5'd1, a, b, 10'd0);
         7'd43: w = xform(6'd31, 5'd1, a, b, 10'd32);
         7'd44: w = dform(6'd11, 5'd1, a, i16);
         7'd45, 7'd46, 7'd47, 7'd48, 7'd49, 7'd50: begin
            case (cmd)
               7'd45:   w = {6'd16, 5'd12, 5'd2, 16'd0};
               7'd46:   w = {6'd16, 5'd4, 5'd2, 16'd0};
               7'd47:   w = {6'd16, 5'd12, 5'd0, 16'd0};
               7'd48:   w = {6'd16, 5'd4, 5'd0, 16'd0};
               7'd49:   w = {6'd16, 5'd12, 5'd1, 16'd0};
               default: w = {6'd16, 5'd4, 5'd1, 16'd0};
            endcase
            w[15:2] = offset[15:2];
            if (offset[1:0] != 2'b00) e = ERR_ALIGN;
            else if (!off16) e = ERR_TOO_LARGE;
         end
         7'd51: begin
            w = {6'd18, offset[25:2], 2'b00};
            if (offset[1:0] != 2'b00) e = ERR_ALIGN;
            else if (offset < -32'sd33554432 || offset > 32'sd33554431) e = ERR_TOO_LARGE;
         end
         7'd52: w = xform(6'd31, d, 5'd9, 5'd0, 10'd467);
         7'd53: w = xform(6'd19, 5'd20, 5'd0, 5'd0, 10'd528) | 32'd1;
         7'd54: w = xform(6'd19, 5'd20, 5'd0, 5'd0, 10'd528);
         7'd55: w = xform(6'd31, d, 5'd8, 5'd0, 10'd339);
         7'd56: w = xform(6'd31, d, 5'd8, 5'd0, 10'd467);
         7'd57: w = xform(6'd19, 5'd20, 5'd0, 5'd0, 10'd16);
         7'd58: w = 32'h6000_0000;
         7'd59: begin w = dform(6'd58, d, a, u16); if (!dok4) e = ERR_ADDRESS; end
         7'd60: begin w = dform(6'd62, d, a, u16); if (!dok4) e = ERR_ADDRESS; end
         7'd61: begin w = dform(6'd62, d, a, u16) | 32'd1; if (!dok4) e = ERR_ADDRESS; end
         7'd62: begin w = dform(6'd32, d, a, u16); if (!dok) e = ERR_ADDRESS; end
         7'd63: begin w = dform(6'd36, d, a, u16); if (!dok) e = ERR_ADDRESS; end
         7'd64: begin w = dform(6'd34, d, a, u16); if (!dok) e = ERR_ADDRESS; end
         7'd65: begin w = dform(6'd38, d, a, u16); if (!dok) e = ERR_ADDRESS; end
         7'd66: begin w = dform(6'd40, d, a, u16); if (!dok) e = ERR_ADDRESS; end
         7'd67: begin w = dform(6'd44, d, a, u16); if (!dok) e = ERR_ADDRESS; end
         7'd68: begin w = dform(6'd35, d, a, u16); if (!dok) e = ERR_ADDRESS; end
         7'd69: begin w = dform(6'd39, d, a, u16); if (!dok) e = ERR_ADDRESS; end
         7'd70: begin w = dform(6'd41, d, a, u16); if (!dok) e = ERR_ADDRESS; end
         7'd71: begin w = dform(6'd42, d, a, u16); if (!dok) e = ERR_ADDRESS; end
         7'd72: begin w = dform(6'd43, d, a, u16); if (!dok) e = ERR_ADDRESS; end
         7'd73: begin w = dform(6'd45, d, a, u16); if (!dok) e = ERR_ADDRESS; end
         7'd74: begin w = dform(6'd33, d, a, u16); if (!dok) e = ERR_ADDRESS; end
         7'd75: begin w = dform(6'd37, d, a, u16); if (!dok) e = ERR_ADDRESS; end
         7'd76: begin w = dform(6'd58, d, a, u16) | 32'd2; if (!dok4) e = ERR_ADDRESS; end
         7'd77: begin w = dform(6'd58, d, a, u16) | 32'd1; if (!dok4) e = ERR_ADDRESS; end
         7'd78: begin w = xform(6'd31, d, a, b, 10'd20); if (!xok) e = ERR_ADDRESS; end
         7'd79: begin w = xform(6'd31, d, a, b, 10'd84); if (!xok) e = ERR_ADDRESS; end
         7'd80: begin
            w = xform(6'd31, d, a, b, 10'd150) | 32'd1; if (!xok) e = ERR_ADDRESS;
         end
         7'd81: begin
            w = xform(6'd31, d, a, b, 10'd214) | 32'd1; if (!xok) e = ERR_ADDRESS;
         end
         7'd82: w = mdform(d, a, sh, mb, 4'd0);
         7'd83: w = mdform(d, a, sh, mb, 4'd4);
         7'd84: w = mdform(d, a, sh, mb, 4'd8);
         7'd85: w = mdform(d, a, sh, mb, 4'd12);
         7'd86: w = mform(6'd21, d, a, sh, mb, me);
         7'd87: w = mform(6'd20, d, a, sh, mb, me);
         7'd88: w = mdform(d, a, 8'd0, sh, 4'd0);
         7'd89: w = mdform(d, a, 8'd0, 8'd63 - sh, 4'd4);
         7'd90: w = mdform(d, a, sh, 8'd0, 4'd0);
         7'd91: w = mdform(d, a, 8'd64 - sh, 8'd0, 4'd0);
         7'd92: w = mdform(d, a, mb, sh - 8'd1, 4'd4);
         7'd93: w = mdform(d, a, mb + sh, 8'd64 - sh, 4'd0);
         7'd94: w = mdform(d, a, 8'd64 - (mb + sh), mb, 4'd12);
         7'd95:  w = xform(6'd31, 5'd0, 5'd0, 5'd0, 10'd598);
         7'd96:  w = xform(6'd31, 5'd1, 5'd0, 5'd0, 10'd598);
         7'd97:  w = xform(6'd19, 5'd0, 5'd0, 5'd0, 10'd150);
         7'd98:  w = xform(6'd31, 5'd0, 5'd0, 5'd0, 10'd854);
         7'd99:  w = xform(6'd31, d, a, 5'd0, 10'd26);
         7'd100: w = xform(6'd31, d, a, 5'd0, 10'd58);
         7'd101: w = xform(6'd31, d, a, 5'd0, 10'd570);
         7'd102: w = xform(6'd31, d, a, 5'd0, 10'd506);
         7'd103, 7'd104: begin
            if (offset < $signed({17'd0, min_frame}) || offset[3:0] != 4'd0
                || offset > 32'sd32764) e = ERR_ARGUMENT;
            else job.kind = (cmd == CMD_PROLOG) ? EXP_PROLOG : EXP_EPILOG;
         end
         default: e = ERR_UNKNOWN;
      endcase
      if (e != ERR_OK) begin
         w = '0;
         job.kind = EXP_ONE;
      end
      job.word  = w;
      job.err   = e;
      job.rd    = d;
      job.imm   = imm;
      job.frame = offset[15:0];
   end

endmodule

/* sv/ppcenc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppcenc_back
// Sequences expansion words of a job and orders the bytes of each beat.
// ----------------------------------------------------------------------------
module ppcenc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  ppcenc_pkg::job_type   job,
   input  logic                  job_valid,
   output logic                  job_take,
   input  logic                  little_endian,
   output ppcenc_pkg::beat_type  beat,
   output logic                  beat_valid,
   input  logic                  beat_take
);
   import ppcenc_pkg::*;

   logic [2:0]  step_ff, step_in;
   logic [31:0] w;
   logic        last;
   logic        hold_ff, hold_in;
   beat_type    beat_ff, beat_in;
   logic        adv;
   logic [4:0]  d;

   always_comb begin
      d = job.rd;
      w = job.word;
      last = 1'b1;
      case (job.kind)
         EXP_LOADIMM: begin
            case (step_ff)
               3'd0: w = dform(6'd15, d, 5'd0, job.imm[63:48]);
               3'd1: w = dform(6'd24, d, d, job.imm[47:32]);
               3'd2: w = mdform(d, d, 8'd32, 8'd31, 4'd4);
               3'd3: w = dform(6'd25, d, d, job.imm[31:16]);
               default: w = dform(6'd24, d, d, job.imm[15:0]);
            endcase
            last = (step_ff == 3'd4);
         end
         EXP_PROLOG: begin
            case (step_ff)
               3'd0: w = xform(6'd31, 5'd0, 5'd8, 5'd0, 10'd339);
               3'd1: w = dform(6'd62, 5'd0, 5'd1, 16'd16);
               default: w = dform(6'd62, 5'd1, 5'd1, 16'd0 - job.frame) | 32'd1;
            endcase
            last = (step_ff == 3'd2);
         end
         EXP_EPILOG: begin
            case (step_ff)
               3'd0: w = dform(6'd14, 5'd1, 5'd1, job.frame);
               3'd1: w = dform(6'd58, 5'd0, 5'd1, 16'd16);
               3'd2: w = xform(6'd31, 5'd0, 5'd8, 5'd0, 10'd467);
               default: w = xform(6'd19, 5'd20, 5'd0, 5'd0, 10'd16);
            endcase
            last = (step_ff == 3'd3);
         end
         default: last = 1'b1;
      endcase
      adv = job_valid && (!hold_ff || beat_take);
      job_take = adv && last;
      step_in = step_ff;
      if (adv) step_in = last ? 3'd0 : step_ff + 3'd1;
      hold_in = hold_ff;
      beat_in = beat_ff;
      if (hold_ff && beat_take) hold_in = 1'b0;
      if (adv) begin
         hold_in = 1'b1;
         beat_in.word = little_endian ? w : {w[7:0], w[15:8], w[23:16], w[31:24]};
         beat_in.err  = job.err;
         beat_in.last = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 3'd0;
         hold_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         hold_ff <= hold_in;
      end
      beat_ff <= beat_in;
   end

   assign beat = beat_ff;
   assign beat_valid = hold_ff;

endmodule

/* sv/ppcenc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppcenc_checker
// Port-level checks on the encoder's result channel.
// ----------------------------------------------------------------------------
module ppcenc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [31:0] rsp_word_bytes,
   input logic [2:0]  rsp_error,
   input logic        rsp_last
);
   import ppcenc_pkg::*;

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_error != ERR_OK |-> rsp_last && rsp_word_bytes == 32'd0)
      else $error("error beat not a single zero word");
   a_err_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_error <= ERR_UNKNOWN)
      else $error("error code out of range");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_word_bytes))
      else $error("stalled beat changed");
   a_reset_empty: assert property (@(posedge clock) !reset && $past(reset) |-> rsp_empty)
      else $error("result after reset");

endmodule

bind ppc64_instruction_encoder ppcenc_checker u_checker (
   .clock(clock), .reset(reset), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
   .rsp_word_bytes(rsp_word_bytes), .rsp_error(rsp_error), .rsp_last(rsp_last)
);

/* dv/tb_ppc64_instruction_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ppc64_instruction_encoder
// Self-checking bench for the PowerPC64 encoder: a directed request table
// followed by random requests under several idling phases and register
// settings. Every result beat is compared with an in-bench encoder.
// ----------------------------------------------------------------------------
module tb_ppc64_instruction_encoder;
   import ppcenc_pkg::*;

   localparam int CMD_LI = 0, CMD_SLDI = 5, CMD_BEQ = 45, CMD_B = 51, CMD_LD = 59;
   localparam int CMD_LWZ = 62, CMD_LWARX = 78, CMD_RLWINM = 86, CMD_INSRDI = 94;
   localparam logic [2:0] ADDR_ENDIAN = 3'd0, ADDR_FRAME = 3'd4;
   localparam int WDOG_LIMIT = 20000;

   typedef struct {
      logic [6:0]  cmd;
      logic [4:0]  rd, ra, rb;
      logic [63:0] imm;
      logic [31:0] off;
      logic [7:0]  sh, mb, me;
      logic        hb, hi;
   } req_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  err;
      logic        last;
   } exp_beat_type;

   logic clock = 0, reset = 1;
   logic req_push = 0, req_full;
   logic [6:0] req_cmd = 0;
   logic [4:0] req_reg_d = 0, req_reg_a = 0, req_reg_b = 0;
   logic [63:0] req_imm = 0;
   logic signed [31:0] req_offset = 0;
   logic [7:0] req_shift = 0, req_mask_begin = 0, req_mask_end = 0;
   logic req_base_en = 0, req_index_en = 0;
   logic rsp_empty, rsp_pop = 0;
   logic [31:0] rsp_word_bytes;
   logic [2:0] rsp_error;
   logic rsp_last;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0, csr_prdata;
   logic csr_pready;

   ppc64_instruction_encoder DUT (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   logic         cfg_le = 1;
   logic [14:0]  cfg_min_frame = 15'd32;
   exp_beat_type words_due[$];
   int           mismatches = 0, reqs_sent = 0, beats_seen = 0, idle_cycles = 0;
   int           send_idle = 0, recv_stall = 0;

   function automatic logic [31:0] fd(int op, logic [4:0] d, logic [4:0] a,
                                      logic [15:0] lo);
      return {op[5:0], d, a, lo};
   endfunction

   function automatic logic [31:0] fx(int op, logic [4:0] d, logic [4:0] a,
                                      logic [4:0] b, int xo);
      return {op[5:0], d, a, b, xo[9:0], 1'b0};
   endfunction

   function automatic logic [31:0] fmd(logic [4:0] s, logic [4:0] a, logic [7:0] sh,
                                       logic [7:0] mb, logic [3:0] k);
      return {6'd30, s, a, sh[4:0], mb[4:0], mb[5], 3'b000, sh[5], 1'b0} | {28'd0, k};
   endfunction

   function automatic logic [31:0] fm(int op, logic [4:0] s, logic [4:0] a,
                                      logic [7:0] sh, logic [7:0] mb, logic [7:0] me);
      return {op[5:0], s, a, sh[4:0], mb[4:0], me[4:0], 1'b0};
   endfunction

   function automatic err_type mem_check(req_type r, logic [1:0] amask);
      logic signed [31:0] o;
      o = r.off;
      if (!r.hb || r.hi || o < -32768 || o > 32767 || (r.off[1:0] & amask) != 0)
         return ERR_ADDRESS;
      return ERR_OK;
   endfunction

   function automatic err_type br_check(req_type r, bit cond);
      logic signed [31:0] o;
      o = r.off;
      if (r.off[1:0] != 0) return ERR_ALIGN;
      if (cond && (o < -32768 || o > 32767)) return ERR_TOO_LARGE;
      if (!cond && (o < -(32'sd1 <<< 25) || o >= (32'sd1 <<< 25))) return ERR_TOO_LARGE;
      return ERR_OK;
   endfunction

   // encode one request into its expected beats
   task automatic encode_request(req_type r);
      logic [31:0] w[5];
      logic [15:0] i;
      logic [7:0] sh, mb;
      logic [4:0] d, a, b;
      logic signed [31:0] o;
      err_type e;
      int n, c;
      exp_beat_type bt;
      w = '{default: 0};
      i = r.imm[15:0]; sh = r.sh; mb = r.mb; d = r.rd; a = r.ra; b = r.rb;
      o = r.off; e = ERR_OK; n = 1; c = r.cmd;
      case (c)
         0: w[0] = fd(14, d, 0, i);
         1: w[0] = fd(14, d, a, i);
         2: w[0] = fd(15, d, a, i);
         3: w[0] = fd(24, d, a, i);
         4: w[0] = fd(25, d, a, i);
         5: w[0] = (sh == 0) ? fx(31, d, a, d, 444) : fmd(d, a, sh, 8'd63 - sh, 4);
         6: begin
            w[0] = fd(15, d, 0, r.imm[63:48]);
            w[1] = fd(24, d, d, r.imm[47:32]);
            w[2] = fmd(d, d, 32, 31, 4);
            w[3] = fd(25, d, d, r.imm[31:16]);
            w[4] = fd(24, d, d, i);
            n = 5;
         end
         7: w[0] = fx(31, d, a, b, 266);   8: w[0] = fx(31, d, a, b, 10);
         9: w[0] = fx(31, d, a, 0, 202);   10: w[0] = fx(31, d, a, 0, 234);
         11: w[0] = fx(31, d, a, b, 40);   12: w[0] = fx(31, d, a, b, 8);
         13: w[0] = fx(31, d, a, 0, 200);  14: w[0] = fx(31, d, a, 0, 232);
         15: w[0] = fx(31, d, a, 0, 104);  16: w[0] = fx(31, d, a, b, 28);
         17: w[0] = fx(31, d, a, b, 444);  18: w[0] = fx(31, d, a, b, 316);
         19: w[0] = fx(31, d, a, b, 27);   20: w[0] = fx(31, d, a, b, 539);
         21: w[0] = fx(31, d, a, b, 794);  22: w[0] = fx(31, d, a, 0, 986);
         23: w[0] = fx(31, d, a, 0, 954);  24: w[0] = fx(31, d, a, 0, 922);
         25: w[0] = fx(31, d, a, b, 233);  26: w[0] = fx(31, d, a, b, 235);
         27: w[0] = fx(31, d, a, b, 9);    28: w[0] = fx(31, d, a, b, 73);
         29: w[0] = fx(31, d, a, b, 75);   30: w[0] = fx(31, d, a, b, 11);
         31: w[0] = fd(7, d, a, i);
         32: w[0] = fx(31, d, a, b, 489);  33: w[0] = fx(31, d, a, b, 491);
         34: w[0] = fx(31, d, a, b, 457);  35: w[0] = fx(31, d, a, b, 459);
         36: w[0] = fx(31, d, a, sh[4:0], 824);
         37: w[0] = fmd(d, a, 8'd64 - sh, sh, 0);
         38: w[0] = fd(28, d, a, i);  39: w[0] = fd(29, d, a, i);
         40: w[0] = fd(26, d, a, i);  41: w[0] = fd(27, d, a, i);
         42: w[0] = fx(31, 1, a, b, 0);
         43: w[0] = fx(31, 1, a, b, 32);
         44: w[0] = fd(11, 1, a, i);
         45, 46, 47, 48, 49, 50: begin
            e = br_check(r, 1);
            w[0] = {6'd16, (c % 2 == 1) ? 5'd12 : 5'd4,
                    (c < 47) ? 5'd2 : (c < 49) ? 5'd0 : 5'd1, r.off[15:2], 2'b00};
         end
         51: begin
            e = br_check(r, 0);
            w[0] = {6'd18, r.off[25:2], 2'b00};
         end
         52: w[0] = fx(31, d, 9, 0, 467);
         53: w[0] = fx(19, 20, 0, 0, 528) | 1;
         54: w[0] = fx(19, 20, 0, 0, 528);
         55: w[0] = fx(31, d, 8, 0, 339);
         56: w[0] = fx(31, d, 8, 0, 467);
         57: w[0] = fx(19, 20, 0, 0, 16);
         58: w[0] = 32'h6000_0000;
         59, 60, 61, 76, 77: begin
            e = mem_check(r, 2'b11);
            w[0] = fd(c == 60 || c == 61 ? 62 : 58, d, a, r.off[15:0])
                   | (c == 61 || c == 77 ? 1 : c == 76 ? 2 : 0);
         end
         62, 63, 64, 65, 66, 67, 68, 69, 70, 71, 72, 73, 74, 75: begin
            int ops[14] = '{32, 36, 34, 38, 40, 44, 35, 39, 41, 42, 43, 45, 33, 37};
            e = mem_check(r, 2'b00);
            w[0] = fd(ops[c - 62], d, a, r.off[15:0]);
         end
         78, 79, 80, 81: begin
            int xos[4] = '{20, 84, 150, 214};
            e = (r.hb && r.hi) ? ERR_OK : ERR_ADDRESS;
            w[0] = fx(31, d, a, b, xos[c - 78]) | (c >= 80 ? 1 : 0);
         end
         82: w[0] = fmd(d, a, sh, mb, 0);  83: w[0] = fmd(d, a, sh, mb, 4);
         84: w[0] = fmd(d, a, sh, mb, 8);  85: w[0] = fmd(d, a, sh, mb, 12);
         86: w[0] = fm(21, d, a, sh, mb, r.me);
         87: w[0] = fm(20, d, a, sh, mb, r.me);
         88: w[0] = fmd(d, a, 0, sh, 0);
         89: w[0] = fmd(d, a, 0, 8'd63 - sh, 4);
         90: w[0] = fmd(d, a, sh, 0, 0);
         91: w[0] = fmd(d, a, 8'd64 - sh, 0, 0);
         92: w[0] = fmd(d, a, mb, sh - 8'd1, 4);
         93: w[0] = fmd(d, a, mb + sh, 8'd64 - sh, 0);
         94: w[0] = fmd(d, a, 8'd64 - (mb + sh), mb, 12);
         95: w[0] = fx(31, 0, 0, 0, 598);  96: w[0] = fx(31, 1, 0, 0, 598);
         97: w[0] = fx(19, 0, 0, 0, 150);  98: w[0] = fx(31, 0, 0, 0, 854);
         99: w[0] = fx(31, d, a, 0, 26);   100: w[0] = fx(31, d, a, 0, 58);
         101: w[0] = fx(31, d, a, 0, 570); 102: w[0] = fx(31, d, a, 0, 506);
         103, 104: begin
            if (o < $signed({17'd0, cfg_min_frame}) || r.off[3:0] != 0 || o > 32764)
               e = ERR_ARGUMENT;
            else if (c == 103) begin
               w[0] = fx(31, 0, 8, 0, 339);
               w[1] = fd(62, 0, 1, 16);
               w[2] = fd(62, 1, 1, 16'd0 - r.off[15:0]) | 1;
               n = 3;
            end else begin
               w[0] = fd(14, 1, 1, r.off[15:0]);
               w[1] = fd(58, 0, 1, 16);
               w[2] = fx(31, 0, 8, 0, 467);
               w[3] = fx(19, 20, 0, 0, 16);
               n = 4;
            end
         end
         default: e = ERR_UNKNOWN;
      endcase
      if (e != ERR_OK) begin
         bt.word = 32'd0;
         bt.err = e;
         bt.last = 1'b1;
         words_due.insert(words_due.size(), bt);
         return;
      end
      for (int k = 0; k < n; k++) begin
         bt.word = cfg_le ? w[k] : {w[k][7:0], w[k][15:8], w[k][23:16], w[k][31:24]};
         bt.err = ERR_OK;
         bt.last = (k == n - 1);
         words_due.insert(words_due.size(), bt);
      end
   endtask

   // result side: pop with random stalls, compare each beat
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            exp_beat_type exp_b;
            beats_seen++;
            if (words_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected beat %h", rsp_word_bytes);
            end else begin
               exp_b = words_due.pop_front();
               if (exp_b.word !== rsp_word_bytes || exp_b.err !== rsp_error ||
                   exp_b.last !== rsp_last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("beat mismatch: exp %h/%0d/%0d got %h/%0d/%0d", exp_b.word,
                              exp_b.err, exp_b.last, rsp_word_bytes, rsp_error, rsp_last);
               end
            end
         end
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WDOG_LIMIT) begin
            $display("[ppc64_instruction_encoder] ERROR");
            $finish;
         end
      end
   end

   always @(negedge clock)
      rsp_pop <= !reset && ($urandom_range(99) >= recv_stall);

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(negedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= addr; csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      if (addr == ADDR_ENDIAN) cfg_le = data[0];
      else cfg_min_frame = data[14:0];
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic drain;
      req_push <= 0;
      while (words_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      @(negedge clock);
   endtask

   // called at a falling edge, returns at a falling edge with push still high
   task automatic send_request(req_type r);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_push <= 0;
         @(negedge clock);
      end
      req_push <= 1; req_cmd <= r.cmd; req_reg_d <= r.rd; req_reg_a <= r.ra;
      req_reg_b <= r.rb; req_imm <= r.imm; req_offset <= r.off; req_shift <= r.sh;
      req_mask_begin <= r.mb; req_mask_end <= r.me;
      req_base_en <= r.hb; req_index_en <= r.hi;
      do @(posedge clock); while (req_full);
      encode_request(r);
      reqs_sent++;
      @(negedge clock);
   endtask

   function automatic req_type rand_request();
      req_type r;
      int pick;
      r.cmd = 7'($urandom_range(104));
      if ($urandom_range(19) == 0) r.cmd = 7'($urandom_range(127, 105));
      r.rd = 5'($urandom); r.ra = 5'($urandom); r.rb = 5'($urandom);
      r.imm = {$urandom, $urandom};
      r.sh = 8'($urandom); r.mb = 8'($urandom); r.me = 8'($urandom);
      r.hb = $urandom_range(7) != 0; r.hi = $urandom_range(3) == 0;
      pick = $urandom_range(9);
      if (pick < 5) r.off = $signed($urandom_range(2047)) - 1024;
      else if (pick < 7) r.off = $signed($urandom_range(65535)) - 32768;
      else if (pick < 8) r.off = $urandom_range(2047) * 16;
      else if (pick < 9) r.off = $signed($urandom_range(32'h3FF_FFFF)) - 32'sh200_0000;
      else r.off = $urandom;
      if ($urandom_range(1)) r.off[1:0] = 0;
      if (r.cmd >= 78 && r.cmd <= 81 && $urandom_range(1)) r.hi = 1;
      return r;
   endfunction

   req_type directed[$];

   initial begin
      req_type r;
      exp_beat_type got_exp;
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 0;

      // directed rows: {cmd, rd, ra, rb, imm, off, sh, mb, me, hb, hi}
      directed = '{
         '{CMD_LI, 31, 0, 0, 64'hFFFF, 0, 0, 0, 0, 0, 0},
         '{CMD_SLDI, 3, 4, 0, 0, 0, 0, 0, 0, 0, 0},
         '{CMD_SLDI, 3, 4, 0, 0, 0, 255, 0, 0, 0, 0},
         '{CMD_LOADIMM, 31, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0},
         '{CMD_LOADIMM, 0, 0, 0, 64'h0123_4567_89AB_CDEF, 0, 0, 0, 0, 0, 0},
         '{CMD_LD, 1, 2, 0, 0, 32767, 0, 0, 0, 1, 0},
         '{CMD_LD, 1, 2, 0, 0, -32768, 0, 0, 0, 1, 0},
         '{CMD_LWZ, 1, 2, 0, 0, 32767, 0, 0, 0, 1, 0},
         '{CMD_LWZ, 1, 2, 0, 0, 32768, 0, 0, 0, 1, 0},
         '{CMD_LWZ, 1, 2, 0, 0, 4, 0, 0, 0, 0, 0},
         '{CMD_LWZ, 1, 2, 0, 0, 4, 0, 0, 0, 1, 1},
         '{CMD_LWARX, 1, 2, 3, 0, 0, 0, 0, 0, 1, 0},
         '{CMD_LWARX, 31, 31, 31, 0, 0, 0, 0, 0, 1, 1},
         '{CMD_BEQ, 0, 0, 0, 0, 2, 0, 0, 0, 0, 0},
         '{CMD_BEQ, 0, 0, 0, 0, 32768, 0, 0, 0, 0, 0},
         '{CMD_BEQ, 0, 0, 0, 0, -32768, 0, 0, 0, 0, 0},
         '{CMD_B, 0, 0, 0, 0, 32'h01FF_FFFC, 0, 0, 0, 0, 0},
         '{CMD_B, 0, 0, 0, 0, 32'h0200_0000, 0, 0, 0, 0, 0},
         '{CMD_B, 0, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0},
         '{CMD_RLWINM, 5, 6, 0, 0, 0, 255, 255, 255, 0, 0},
         '{CMD_INSRDI, 5, 6, 0, 0, 0, 200, 100, 0, 0, 0},
         '{CMD_PROLOG, 0, 0, 0, 0, 16, 0, 0, 0, 0, 0},
         '{CMD_PROLOG, 0, 0, 0, 0, 32752, 0, 0, 0, 0, 0},
         '{CMD_EPILOG, 0, 0, 0, 0, 32, 0, 0, 0, 0, 0},
         '{7'd127, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
      };
      foreach (directed[k]) begin
         send_request(directed[k]);
         // rows with an obvious outcome: check the prediction too
         got_exp = words_due[$];
         if ((directed[k].cmd == 127 && got_exp.err != ERR_UNKNOWN) ||
             (k == 14 && got_exp.err != ERR_TOO_LARGE) ||
             (k == 13 && got_exp.err != ERR_ALIGN) ||
             (k == 21 && got_exp.err != ERR_ARGUMENT) ||
             (k == 8 && got_exp.err != ERR_ADDRESS)) begin
            mismatches++;
            if (mismatches <= 10) $display("directed row %0d predicted %0d", k, got_exp.err);
         end
      end
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 88; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 88; end
            3: begin send_idle = 18; recv_stall = 18; end
            4: begin send_idle = 0;  recv_stall = 0;  end
            default: begin send_idle = 18; recv_stall = 50; end
         endcase
         csr_write(ADDR_ENDIAN, ph % 2 == 0 ? 32'd0 : 32'd1);
         csr_write(ADDR_FRAME, ph == 2 ? 32'd0 : ph == 4 ? 32'd32764 :
                   ph == 5 ? 32'h7FFF : $urandom_range(512));
         for (int k = 0; k < 75; k++) begin
            r = rand_request();
            send_request(r);
            if (k == 40) drain();
         end
         drain();
      end
      csr_write(ADDR_ENDIAN, 1);
      csr_write(ADDR_FRAME, 32);
      repeat (10) @(posedge clock);

      $display("%0d requests encoded, %0d beats checked, six idling phases, both byte orders",
               reqs_sent, beats_seen);
      if (mismatches == 0 && words_due.size() == 0)
         $display("[ppc64_instruction_encoder] OK");
      else
         $display("[ppc64_instruction_encoder] ERROR");
      $finish;
   end
endmodule

/* filelist.f */
sv/ppcenc_pkg.sv
sv/ppcenc_front.sv
sv/ppcenc_back.sv
sv/ppc64_instruction_encoder.sv
sv/ppcenc_checker.sv
dv/tb_ppc64_instruction_encoder.sv
